// ----- design/ugrt_pkg.sv -----
// Shared types and constants for the uniform grid ray traversal block.
// Used by the controller, the datapath and the top level; no dependencies.
package ugrt_pkg;

  // default grid size limit per axis
  localparam int MAX_CELLS_DEFAULT = 64;

  // bits of quotient produced by the iterative divider, one per cycle
  localparam int DIV_BITS = 32;

  // saturation bounds of the 40-bit signed Q24.16 crossing values
  localparam logic signed [39:0] T40_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] T40_MIN = -40'sh80_0000_0000;

  // item commands
  localparam logic CMD_SETUP = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // axis codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // direction and step codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] STEP_POS = 2'b01;
  localparam logic [1:0] STEP_NEG = 2'b11;

  // configuration register indexes
  localparam logic [2:0] CFG_CELLS_X = 3'd0;
  localparam logic [2:0] CFG_CELLS_Y = 3'd1;
  localparam logic [2:0] CFG_CELLS_Z = 3'd2;
  localparam logic [2:0] CFG_SCALE_X = 3'd3;
  localparam logic [2:0] CFG_SCALE_Y = 3'd4;
  localparam logic [2:0] CFG_SCALE_Z = 3'd5;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DT,
    ST_KMUL,
    ST_COMMIT,
    ST_ADV,
    ST_LIN1,
    ST_LIN2,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic dt_load;
    logic kmul;
    logic commit;
    logic adv;
    logic lin1;
    logic lin2;
    logic emit;
  } dp_cmd_t;

endpackage

// ----- design/ugrt_ctrl.sv -----
// Controller state machine of the ray traversal block.
// Sequences setup and step transactions; depends on ugrt_pkg.
module ugrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  logic [1:0]         in_axis,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ugrt_pkg::dp_cmd_t  cmd
);

  localparam int CW = $clog2(ugrt_pkg::DIV_BITS);

  ugrt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ugrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == ugrt_pkg::CMD_STEP) state_nxt = ugrt_pkg::ST_ADV;
          else if (in_axis != ugrt_pkg::AXIS_NONE) state_nxt = ugrt_pkg::ST_MUL;
        end
      end
      ugrt_pkg::ST_MUL:    state_nxt = ugrt_pkg::ST_DIV;
      ugrt_pkg::ST_DIV: begin
        if (cnt_r == CW'(ugrt_pkg::DIV_BITS - 1)) state_nxt = ugrt_pkg::ST_DT;
      end
      ugrt_pkg::ST_DT:     state_nxt = ugrt_pkg::ST_KMUL;
      ugrt_pkg::ST_KMUL:   state_nxt = ugrt_pkg::ST_COMMIT;
      ugrt_pkg::ST_COMMIT: state_nxt = ugrt_pkg::ST_LIN1;
      ugrt_pkg::ST_ADV:    state_nxt = ugrt_pkg::ST_LIN1;
      ugrt_pkg::ST_LIN1:   state_nxt = ugrt_pkg::ST_LIN2;
      ugrt_pkg::ST_LIN2:   state_nxt = ugrt_pkg::ST_EMIT;
      ugrt_pkg::ST_EMIT: begin
        if (out_free) state_nxt = ugrt_pkg::ST_IDLE;
      end
      default:             state_nxt = ugrt_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ugrt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ugrt_pkg::ST_MUL:    cmd.mul      = 1'b1;
      ugrt_pkg::ST_DIV:    cmd.div_step = 1'b1;
      ugrt_pkg::ST_DT:     cmd.dt_load  = 1'b1;
      ugrt_pkg::ST_KMUL:   cmd.kmul     = 1'b1;
      ugrt_pkg::ST_COMMIT: cmd.commit   = 1'b1;
      ugrt_pkg::ST_ADV:    cmd.adv      = 1'b1;
      ugrt_pkg::ST_LIN1:   cmd.lin1     = 1'b1;
      ugrt_pkg::ST_LIN2:   cmd.lin2     = 1'b1;
      ugrt_pkg::ST_EMIT:   cmd.emit     = out_free;
      default:             cmd          = '0;
    endcase
  end

  // state, divider count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ugrt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ugrt_pkg::ST_MUL) cnt_r <= '0;
      else if (state_r == ugrt_pkg::ST_DIV) cnt_r <= cnt_r + CW'(1);
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- design/ugrt_dp.sv -----
// Datapath of the ray traversal block: configuration, per-axis state,
// setup multiply and divider, step compare and add, linear index. Uses ugrt_pkg.
module ugrt_dp #(
  parameter int MAX_CELLS_PER_AXIS = ugrt_pkg::MAX_CELLS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ugrt_pkg::dp_cmd_t        cmd,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_wdata,
  input  logic [1:0]               in_axis,
  input  logic signed [31:0]       in_entry_offset,
  input  logic signed [31:0]       in_origin_offset,
  input  logic                     in_ray_inside,
  input  logic signed [1:0]        in_dir_sign,
  input  logic signed [31:0]       in_slab_t_min,
  input  logic signed [31:0]       in_slab_t_max,
  output logic signed [7:0]        out_cell_x,
  output logic signed [7:0]        out_cell_y,
  output logic signed [7:0]        out_cell_z,
  output logic [17:0]              out_linear_index,
  output logic [1:0]               out_moved_axis,
  output logic                     out_exited
);

  localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int SW = 48;

  // configuration registers
  logic [6:0]  cells_x_r, cells_y_r, cells_z_r;
  logic [31:0] scale_x_r, scale_y_r, scale_z_r;

  // per-axis traversal state
  logic [7:0]         axis_cell_r   [3];
  logic [1:0]         axis_step_r   [3];
  logic [7:0]         axis_stop_r   [3];
  logic signed [31:0] axis_delta_r  [3];
  logic signed [39:0] axis_next_r   [3];

  // setup working registers
  logic [1:0]          axis_r;
  logic signed [31:0]  start_r;
  logic [31:0]         scale_r;
  logic signed [31:0]  tmin_r;
  logic [1:0]          dir_r;
  logic [NW-1:0]       n_r;
  logic signed [63:0]  prod_r;
  logic [31:0]         dq_r;
  logic [NW-1:0]       rem_r;
  logic                neg_r;
  logic [7:0]          cell_r;
  logic signed [31:0]  dt_r;
  logic signed [NW+32:0] kd_r;

  // result working registers
  logic [1:0]  mv_r;
  logic        ex_r;
  logic [17:0] p1_r, p2_r, p3_r;

  // saturate raw cell count to 1..MAX
  function automatic logic [NW-1:0] eff_cells(input logic [6:0] v);
    logic [8:0] w;
    w = 9'(v);
    if (w == 9'd0) w = 9'd1;
    if (w > 9'(MAX_CELLS_PER_AXIS)) w = 9'(MAX_CELLS_PER_AXIS);
    return NW'(w);
  endfunction

  logic [NW-1:0] nx, ny, n_sel;
  logic [31:0]   scale_sel;
  logic signed [32:0] diff;

  assign nx = eff_cells(cells_x_r);
  assign ny = eff_cells(cells_y_r);

  // per-axis selection at capture
  always_comb begin
    unique case (in_axis)
      ugrt_pkg::AXIS_X: begin n_sel = nx; scale_sel = scale_x_r; end
      ugrt_pkg::AXIS_Y: begin n_sel = ny; scale_sel = scale_y_r; end
      default:          begin n_sel = eff_cells(cells_z_r); scale_sel = scale_z_r; end
    endcase
  end

  assign diff = 33'(in_slab_t_max) - 33'(in_slab_t_min);

  // start times scale
  logic signed [64:0] prod_full;
  assign prod_full = $signed(start_r) * $signed({1'b0, scale_r});

  // one restoring divider step
  logic [NW:0]   div_sh;
  logic          div_ge;
  assign div_sh = {rem_r, dq_r[31]};
  assign div_ge = div_sh >= {1'b0, n_r};

  // clamped start cell
  logic [NW-1:0] nm1;
  logic [7:0]    cell_clamp;
  assign nm1 = n_r - NW'(1);
  always_comb begin
    if (prod_r[63]) cell_clamp = 8'd0;
    else if (prod_r[63:32] > 32'(nm1)) cell_clamp = 8'(nm1);
    else cell_clamp = prod_r[39:32];
  end

  // signed quotient saturated to 32 bits
  logic signed [31:0] dt_sat;
  always_comb begin
    if (!neg_r) dt_sat = dq_r[31] ? 32'sh7FFF_FFFF : $signed(dq_r);
    else if (dq_r > 32'h8000_0000) dt_sat = 32'sh8000_0000;
    else dt_sat = $signed(-dq_r);
  end

  // crossing multiplier k and first crossing
  logic          dir_pos;
  logic [NW-1:0] k;
  logic signed [SW-1:0] next_full;
  logic signed [39:0]   next_sat;
  logic [15:0]          n_ext;
  assign dir_pos = dir_r == ugrt_pkg::DIR_POS;
  assign k = dir_pos ? NW'(cell_r) + NW'(1) : n_r - NW'(cell_r);
  assign next_full = SW'(tmin_r) + SW'(kd_r);
  assign n_ext = 16'(n_r);
  always_comb begin
    if (dir_r == ugrt_pkg::DIR_NONE) next_sat = ugrt_pkg::T40_MAX;
    else if (next_full > SW'(ugrt_pkg::T40_MAX)) next_sat = ugrt_pkg::T40_MAX;
    else if (next_full < SW'(ugrt_pkg::T40_MIN)) next_sat = ugrt_pkg::T40_MIN;
    else next_sat = next_full[39:0];
  end

  // step: pick axis with smallest crossing; ties go to z, then y, and x wins only when strictly smallest
  logic [1:0]         sa;
  logic signed [40:0] adv_sum;
  logic signed [39:0] adv_sat;
  logic [7:0]         adv_cell;
  always_comb begin
    priority if (axis_next_r[0] < axis_next_r[1] && axis_next_r[0] < axis_next_r[2])
      sa = ugrt_pkg::AXIS_X;
    else if (axis_next_r[1] < axis_next_r[2])
      sa = ugrt_pkg::AXIS_Y;
    else
      sa = ugrt_pkg::AXIS_Z;
  end
  assign adv_sum  = 41'(axis_next_r[sa]) + 41'(axis_delta_r[sa]);
  assign adv_cell = axis_cell_r[sa] + {{6{axis_step_r[sa][1]}}, axis_step_r[sa]};
  always_comb begin
    if (adv_sum > 41'(ugrt_pkg::T40_MAX)) adv_sat = ugrt_pkg::T40_MAX;
    else if (adv_sum < 41'(ugrt_pkg::T40_MIN)) adv_sat = ugrt_pkg::T40_MIN;
    else adv_sat = adv_sum[39:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= 7'd1;
      cells_y_r <= 7'd1;
      cells_z_r <= 7'd1;
      scale_x_r <= 32'd65536;
      scale_y_r <= 32'd65536;
      scale_z_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugrt_pkg::CFG_CELLS_X: cells_x_r <= cfg_wdata[6:0];
        ugrt_pkg::CFG_CELLS_Y: cells_y_r <= cfg_wdata[6:0];
        ugrt_pkg::CFG_CELLS_Z: cells_z_r <= cfg_wdata[6:0];
        ugrt_pkg::CFG_SCALE_X: scale_x_r <= cfg_wdata;
        ugrt_pkg::CFG_SCALE_Y: scale_y_r <= cfg_wdata;
        ugrt_pkg::CFG_SCALE_Z: scale_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-axis state: setup commit and step advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        axis_cell_r[i]  <= '0;
        axis_step_r[i]  <= '0;
        axis_stop_r[i]  <= '0;
        axis_delta_r[i] <= '0;
        axis_next_r[i]  <= '0;
      end
    end else if (cmd.commit) begin
      axis_cell_r[axis_r]  <= cell_r;
      axis_step_r[axis_r]  <= dir_pos ? ugrt_pkg::STEP_POS : ugrt_pkg::STEP_NEG;
      axis_stop_r[axis_r]  <= dir_pos ? n_ext[7:0] : 8'hFF;
      axis_delta_r[axis_r] <= dt_r;
      axis_next_r[axis_r]  <= next_sat;
    end else if (cmd.adv) begin
      axis_cell_r[sa] <= adv_cell;
      axis_next_r[sa] <= adv_sat;
    end
  end

  // setup working registers and divider
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      axis_r  <= in_axis;
      start_r <= in_ray_inside ? in_origin_offset : in_entry_offset;
      scale_r <= scale_sel;
      tmin_r  <= in_slab_t_min;
      dir_r   <= in_dir_sign;
      n_r     <= n_sel;
      neg_r   <= diff[32];
      dq_r    <= diff[32] ? 32'(-diff) : diff[31:0];
      rem_r   <= '0;
    end
    if (cmd.mul) prod_r <= prod_full[63:0];
    if (cmd.div_step) begin
      rem_r <= div_ge ? NW'(div_sh - {1'b0, n_r}) : div_sh[NW-1:0];
      dq_r  <= {dq_r[30:0], div_ge};
    end
    if (cmd.dt_load) begin
      cell_r <= cell_clamp;
      dt_r   <= dt_sat;
    end
    if (cmd.kmul) kd_r <= $signed({1'b0, k}) * dt_r;
  end

  // result flags, index products and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mv_r <= in_axis;
      ex_r <= 1'b0;
    end
    if (cmd.adv) begin
      mv_r <= sa;
      ex_r <= adv_cell == axis_stop_r[sa];
    end
    if (cmd.lin1) begin
      p1_r <= 18'(nx * axis_cell_r[1]);
      p2_r <= 18'(nx * ny);
    end
    if (cmd.lin2) p3_r <= 18'(p2_r * axis_cell_r[2]);
    if (cmd.emit) begin
      out_cell_x       <= $signed(axis_cell_r[0]);
      out_cell_y       <= $signed(axis_cell_r[1]);
      out_cell_z       <= $signed(axis_cell_r[2]);
      out_linear_index <= ex_r ? 18'd0 : 18'(axis_cell_r[0]) + p1_r + p3_r;
      out_moved_axis   <= mv_r;
      out_exited       <= ex_r;
    end
  end

endmodule

// ----- design/uniform_grid_ray_traversal.sv -----
// Top level of the uniform grid ray traversal block (3D DDA walker).
// Joins ugrt_ctrl and ugrt_dp; depends on ugrt_pkg.

// One transaction at a time. A step transaction goes from acceptance to a
// result in the output register through the compare and add, two linear
// index multiply steps, then the output load; a setup transaction goes
// through the start multiply, the bit-serial divider that forms the crossing
// spacing, the quotient saturation, the crossing multiply, the commit, two
// linear index steps and the output load. A setup of axis code three is
// accepted and gives no result. The next transaction is accepted while a
// result still waits in the output register. Configuration writes take
// effect at once and must be made while the block is idle.
module uniform_grid_ray_traversal #(
  parameter int MAX_CELLS_PER_AXIS = ugrt_pkg::MAX_CELLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_entry_offset,
  input  logic signed [31:0] in_origin_offset,
  input  logic               in_ray_inside,
  input  logic signed [1:0]  in_dir_sign,
  input  logic signed [31:0] in_slab_t_min,
  input  logic signed [31:0] in_slab_t_max,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_cell_x,
  output logic signed [7:0]  out_cell_y,
  output logic signed [7:0]  out_cell_z,
  output logic [17:0]        out_linear_index,
  output logic [1:0]         out_moved_axis,
  output logic               out_exited
);

  ugrt_pkg::dp_cmd_t cmd;

  // controller
  ugrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_axis   (in_axis),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  ugrt_dp #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_axis          (in_axis),
    .in_entry_offset  (in_entry_offset),
    .in_origin_offset (in_origin_offset),
    .in_ray_inside    (in_ray_inside),
    .in_dir_sign      (in_dir_sign),
    .in_slab_t_min    (in_slab_t_min),
    .in_slab_t_max    (in_slab_t_max),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_cell_z       (out_cell_z),
    .out_linear_index (out_linear_index),
    .out_moved_axis   (out_moved_axis),
    .out_exited       (out_exited)
  );

endmodule

// ----- design/ugrt_checker.sv -----
// Port-level assertions for the uniform grid ray traversal block.
// Bound to uniform_grid_ray_traversal; depends on ugrt_pkg for the axis codes.
module ugrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_linear_index,
  input logic [1:0]  out_moved_axis,
  input logic        out_exited
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_index))
    else $error("stalled result changed");

  // an exited result carries a zero linear index
  a_exit_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exited |-> out_linear_index == 18'd0)
    else $error("exited result with nonzero index");

  // results never name the unused axis code
  a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_moved_axis != ugrt_pkg::AXIS_NONE)
    else $error("result names axis three");

  // a step transaction keeps the block busy in the next cycle
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd |=> in_stall)
    else $error("input accepted right after a step");

endmodule

bind uniform_grid_ray_traversal ugrt_checker u_ugrt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_linear_index (out_linear_index),
  .out_moved_axis   (out_moved_axis),
  .out_exited       (out_exited)
);
